>>> hdl/fcew_pkg.sv
package fcew_pkg;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_RUN    = 8'b0000_0010,
      ST_STEP   = 8'b0000_0100,
      ST_ADDR   = 8'b0000_1000,
      ST_READ   = 8'b0001_0000,
      ST_ACC    = 8'b0010_0000,
      ST_DECODE = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      FAT_12 = 2'd0,
      FAT_16 = 2'd1,
      FAT_32 = 2'd2,
      FAT_NONE = 2'd3
   } fat_kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_LIMIT = 2'd3
   } status_type;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_WALK = 1'b1;

   localparam int unsigned CSR_FAT_TYPE = 0;

   localparam logic [11:0] FAT12_MASK = 12'hFFF;
   localparam logic [11:0] FAT12_EOC  = 12'hFF8;
   localparam logic [15:0] FAT16_EOC  = 16'hFFF8;
   localparam logic [27:0] FAT32_MASK = 28'hFFF_FFFF;
   localparam logic [27:0] FAT32_EOC  = 28'hFFF_FFF8;

   function automatic logic [27:0] next_cluster(fat_kind_type ft, logic odd,
                                                logic [31:0] raw);
      logic [11:0] v12;
      logic [15:0] v16;
      logic [27:0] v32;
      logic [27:0] nx;
      v12 = odd ? raw[15:4] : (raw[11:0] & FAT12_MASK);
      v16 = raw[15:0];
      v32 = raw[27:0] & FAT32_MASK;
      unique case (ft)
         FAT_12: nx = (v12 >= FAT12_EOC) ? 28'd0 : {16'd0, v12};
         FAT_16: nx = (v16 >= FAT16_EOC) ? 28'd0 : {12'd0, v16};
         FAT_32: nx = (v32 >= FAT32_EOC) ? 28'd0 : v32;
         default: nx = 28'd0;
      endcase
      return nx;
   endfunction

endpackage

>>> hdl/fcew_ifs.sv
interface fcew_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] byte_address;
   logic [7:0]  byte_value;
   logic [27:0] first_cluster;

   modport source (output valid, kind, byte_address, byte_value, first_cluster,
                   input ready);
   modport sink (input valid, kind, byte_address, byte_value, first_cluster,
                 output ready);
endinterface

interface fcew_rsp_if;
   logic        valid;
   logic        ready;
   logic [27:0] extent_start;
   logic [27:0] run_end_count;
   logic        last_extent;
   logic [1:0]  status;

   modport source (output valid, extent_start, run_end_count, last_extent, status,
                   input ready);
   modport sink (input valid, extent_start, run_end_count, last_extent, status,
                 output ready);
endinterface

>>> hdl/fcew_fat_ram.sv
module fcew_fat_ram #(
   parameter int unsigned DEPTH  = 65536,
   parameter int unsigned ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

>>> hdl/fat_chain_extent_walker.sv
// channel   | dir | handshake          | word
// ----------+-----+--------------------+------------------------------------------
// req_ch    | in  | valid/ready        | kind, byte_address, byte_value, first_cluster
// rsp_ch    | out | valid/ready        | extent_start, run_end_count, last_extent, status
// csr_*     | in  | APB write/read     | fat_type at byte address 0
//
// A load word writes its byte when accepted. A walk reads B bytes per chain entry
// through the byte store's single read port (B = 2 for FAT12/FAT16, 4 for FAT32).
// req_ch.ready is high only while idle; results sit in an output register, so a
// stalled rsp_ch holds the walk only when the next result is due.
// Reset is synchronous and clears control state; the byte store is not cleared.
module fat_chain_extent_walker #(
   parameter int unsigned FAT_BYTES   = 65536,
   parameter int unsigned MAX_EXTENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   fcew_req_if.sink    req_ch,
   fcew_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned ADDR_W = $clog2(FAT_BYTES);
   localparam logic [30:0] STORE_END = 31'(FAT_BYTES);
   localparam logic [6:0]  EXT_LIMIT = 7'(MAX_EXTENTS);

   fcew_pkg::state_type    state_ff, state_in;
   fcew_pkg::fat_kind_type fat_type_ff;
   logic [27:0]       cur_ff, cur_in;
   logic [27:0]       start_ff, start_in;
   logic [27:0]       total_ff, total_in;
   logic [6:0]        ext_ff, ext_in;
   logic [1:0]        idx_ff, idx_in;
   logic [ADDR_W-1:0] off_ff, off_in;
   logic [31:0]       acc_ff, acc_in;
   logic              pend_last_ff, pend_last_in;
   fcew_pkg::status_type pend_stat_ff, pend_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [27:0]       o_start_ff, o_start_in;
   logic [27:0]       o_count_ff, o_count_in;
   logic              o_last_ff, o_last_in;
   fcew_pkg::status_type o_stat_ff, o_stat_in;

   logic              csr_wr;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;
   logic              req_fire;
   logic              out_free;
   logic              no_succ;
   logic [30:0]       off_wide;
   logic [30:0]       off_end;
   logic [1:0]        last_idx;
   logic [27:0]       nx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {30'd0, fat_type_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         fat_type_ff <= fcew_pkg::FAT_12;
      end else if (csr_wr) begin
         fat_type_ff <= fcew_pkg::fat_kind_type'(csr_pwdata[1:0]);
      end
   end

   assign req_ch.ready = (state_ff == fcew_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign ram_we    = req_fire && (req_ch.kind == fcew_pkg::KIND_LOAD)
                      && ({16'd0, req_ch.byte_address} < 32'(FAT_BYTES));
   assign ram_waddr = ADDR_W'(req_ch.byte_address);
   assign ram_raddr = off_ff + ADDR_W'(idx_ff);

   fcew_fat_ram #(
      .DEPTH  (FAT_BYTES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (req_ch.byte_value),
      .rd_addr    (ram_raddr),
      .rd_data_ff (ram_rdata)
   );

   always_comb begin
      unique case (fat_type_ff)
         fcew_pkg::FAT_12: begin
            no_succ  = cur_ff >= {16'd0, fcew_pkg::FAT12_EOC};
            off_wide = {3'd0, cur_ff} + {4'd0, cur_ff[27:1]};
            last_idx = 2'd1;
         end
         fcew_pkg::FAT_16: begin
            no_succ  = cur_ff >= {12'd0, fcew_pkg::FAT16_EOC};
            off_wide = {2'd0, cur_ff, 1'b0};
            last_idx = 2'd1;
         end
         fcew_pkg::FAT_32: begin
            no_succ  = cur_ff >= fcew_pkg::FAT32_EOC;
            off_wide = {1'b0, cur_ff, 2'd0};
            last_idx = 2'd3;
         end
         default: begin
            no_succ  = 1'b1;
            off_wide = 31'd0;
            last_idx = 2'd1;
         end
      endcase
   end

   assign off_end  = off_wide + {29'd0, last_idx} + 31'd1;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign nx       = fcew_pkg::next_cluster(fat_type_ff, cur_ff[0], acc_ff);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      total_in     = total_ff;
      ext_in       = ext_ff;
      idx_in       = idx_ff;
      off_in       = off_ff;
      acc_in       = acc_ff;
      pend_last_in = pend_last_ff;
      pend_stat_in = pend_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      o_start_in   = o_start_ff;
      o_count_in   = o_count_ff;
      o_last_in    = o_last_ff;
      o_stat_in    = o_stat_ff;
      unique case (state_ff)
         fcew_pkg::ST_IDLE: begin
            if (req_fire && (req_ch.kind == fcew_pkg::KIND_WALK)) begin
               cur_in   = req_ch.first_cluster;
               total_in = 28'd0;
               ext_in   = 7'd0;
               if (req_ch.first_cluster < 28'd2) begin
                  start_in     = 28'd2;
                  pend_last_in = 1'b1;
                  pend_stat_in = fcew_pkg::STAT_EMPTY;
                  state_in     = fcew_pkg::ST_EMIT;
               end else begin
                  state_in = fcew_pkg::ST_RUN;
               end
            end
         end
         fcew_pkg::ST_RUN: begin
            start_in = cur_ff;
            ext_in   = ext_ff + 7'd1;
            state_in = fcew_pkg::ST_STEP;
         end
         fcew_pkg::ST_STEP: begin
            total_in = total_ff + 28'd1;
            state_in = fcew_pkg::ST_ADDR;
         end
         fcew_pkg::ST_ADDR: begin
            acc_in = 32'd0;
            idx_in = 2'd0;
            if (no_succ) begin
               state_in = fcew_pkg::ST_DECODE;
            end else if (off_end > STORE_END) begin
               pend_last_in = 1'b1;
               pend_stat_in = fcew_pkg::STAT_RANGE;
               state_in     = fcew_pkg::ST_EMIT;
            end else begin
               off_in   = ADDR_W'(off_wide);
               state_in = fcew_pkg::ST_READ;
            end
         end
         fcew_pkg::ST_READ: begin
            state_in = fcew_pkg::ST_ACC;
         end
         fcew_pkg::ST_ACC: begin
            acc_in = acc_ff | ({24'd0, ram_rdata} << {idx_ff, 3'd0});
            if (idx_ff == last_idx) begin
               state_in = fcew_pkg::ST_DECODE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = fcew_pkg::ST_READ;
            end
         end
         fcew_pkg::ST_DECODE: begin
            cur_in = nx;
            if ({1'b0, nx} == ({1'b0, cur_ff} + 29'd1)) begin
               state_in = fcew_pkg::ST_STEP;
            end else begin
               state_in     = fcew_pkg::ST_EMIT;
               pend_stat_in = fcew_pkg::STAT_OK;
               if (nx < 28'd2) begin
                  pend_last_in = 1'b1;
               end else if (ext_ff >= EXT_LIMIT) begin
                  pend_last_in = 1'b1;
                  pend_stat_in = fcew_pkg::STAT_LIMIT;
               end else begin
                  pend_last_in = 1'b0;
               end
            end
         end
         fcew_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_start_in   = start_ff - 28'd2;
               o_count_in   = total_ff;
               o_last_in    = pend_last_ff;
               o_stat_in    = pend_stat_ff;
               state_in     = pend_last_ff ? fcew_pkg::ST_IDLE : fcew_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = fcew_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcew_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= 28'd0;
         total_ff     <= 28'd0;
         ext_ff       <= 7'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         total_ff     <= total_in;
         ext_ff       <= ext_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      idx_ff       <= idx_in;
      off_ff       <= off_in;
      acc_ff       <= acc_in;
      pend_last_ff <= pend_last_in;
      pend_stat_ff <= pend_stat_in;
      o_start_ff   <= o_start_in;
      o_count_ff   <= o_count_in;
      o_last_ff    <= o_last_in;
      o_stat_ff    <= o_stat_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.extent_start  = o_start_ff;
   assign rsp_ch.run_end_count = o_count_ff;
   assign rsp_ch.last_extent   = o_last_ff;
   assign rsp_ch.status        = o_stat_ff;

endmodule

>>> tb/tb_fat_chain_extent_walker.sv
`timescale 1ns / 100ps

module tb_fat_chain_extent_walker;

   localparam int unsigned FAT_BYTES      = 65536;
   localparam int unsigned MAX_EXTENTS    = 64;
   localparam int          SETTLE_CYCLES  = 20;
   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          PRINT_CAP      = 40;

   typedef struct packed {
      logic        kind;
      logic [15:0] addr;
      logic [7:0]  val;
      logic [27:0] head;
   } req_word_type;

   typedef struct packed {
      logic [27:0]          start_cl;
      logic [27:0]          end_count;
      logic                 last_flag;
      fcew_pkg::status_type status;
   } extent_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fcew_req_if req_ch ();
   fcew_rsp_if rsp_ch ();

   fat_chain_extent_walker #(
      .FAT_BYTES   (FAT_BYTES),
      .MAX_EXTENTS (MAX_EXTENTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bit [7:0]               fat_mem  [0:FAT_BYTES-1];
   bit [7:0]               plan_mem [0:FAT_BYTES-1];
   bit                     plan_set [0:FAT_BYTES-1];
   fcew_pkg::fat_kind_type fat_sel;

   req_word_type pending_words [$];
   extent_type   expected_extents [$];
   req_word_type cur_word;
   extent_type   want;

   int          words_queued;
   int          words_taken;
   int          error_count;
   int          idle_cycles;
   int          burst_left;
   int          gap_left;
   int          stall_left;
   bit          rsp_open;
   bit          free_flow;
   bit          dry_miss;
   logic [15:0] miss_addr;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_error(input string msg);
      if (error_count < PRINT_CAP)
         $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [7:0] fat_byte(input int unsigned a, input bit dry);
      if (dry) begin
         if (!plan_set[a] && !dry_miss) begin
            dry_miss  = 1'b1;
            miss_addr = 16'(a);
         end
         return plan_mem[a];
      end
      return fat_mem[a];
   endfunction

   // Returns 0 when the entry lies past the end of the table.
   function automatic bit fat_link(input logic [27:0] c, input bit dry,
                                   output logic [27:0] nx);
      int unsigned off;
      logic [31:0] raw;
      nx = 28'd0;
      unique case (fat_sel)
         fcew_pkg::FAT_12: begin
            if (c >= {16'd0, fcew_pkg::FAT12_EOC}) return 1'b1;
            off = c + (c >> 1);
            if (off + 2 > FAT_BYTES) return 1'b0;
            raw = {16'd0, fat_byte(off + 1, dry), fat_byte(off, dry)};
            raw = c[0] ? (raw >> 4) : (raw & 32'h0000_0FFF);
            nx = (raw[11:0] >= fcew_pkg::FAT12_EOC) ? 28'd0 : {16'd0, raw[11:0]};
         end
         fcew_pkg::FAT_16: begin
            if (c >= {12'd0, fcew_pkg::FAT16_EOC}) return 1'b1;
            off = c * 2;
            if (off + 2 > FAT_BYTES) return 1'b0;
            raw = {16'd0, fat_byte(off + 1, dry), fat_byte(off, dry)};
            nx = (raw[15:0] >= fcew_pkg::FAT16_EOC) ? 28'd0 : {12'd0, raw[15:0]};
         end
         fcew_pkg::FAT_32: begin
            if (c >= fcew_pkg::FAT32_EOC) return 1'b1;
            off = c * 4;
            if (off + 4 > FAT_BYTES) return 1'b0;
            raw = {fat_byte(off + 3, dry), fat_byte(off + 2, dry),
                   fat_byte(off + 1, dry), fat_byte(off, dry)};
            nx = (raw[27:0] >= fcew_pkg::FAT32_EOC) ? 28'd0 : raw[27:0];
         end
         default: ;
      endcase
      return 1'b1;
   endfunction

   function automatic void post_extent(input bit dry, input logic [27:0] s,
                                       input logic [27:0] n, input logic l,
                                       input fcew_pkg::status_type st);
      extent_type e;
      if (!dry) begin
         e.start_cl  = s;
         e.end_count = n;
         e.last_flag = l;
         e.status    = st;
         expected_extents.push_back(e);
      end
   endfunction

   // Follow the chain from head and split it into contiguous runs.
   function automatic void walk_extents(input logic [27:0] head, input bit dry);
      logic [27:0] cur;
      logic [27:0] run_start;
      logic [27:0] nx;
      logic [27:0] total;
      int          extents;
      bit          in_range;
      cur     = head;
      total   = 28'd0;
      extents = 0;
      if (head < 28'd2) begin
         post_extent(dry, 28'd0, 28'd0, 1'b1, fcew_pkg::STAT_EMPTY);
         return;
      end
      while (1) begin
         run_start = cur;
         extents++;
         while (1) begin
            total    = total + 28'd1;
            in_range = fat_link(cur, dry, nx);
            if (dry && dry_miss) return;
            if (!in_range) begin
               post_extent(dry, run_start - 28'd2, total, 1'b1, fcew_pkg::STAT_RANGE);
               return;
            end
            if ({1'b0, nx} != ({1'b0, cur} + 29'd1)) break;
            cur = nx;
         end
         cur = nx;
         if (nx < 28'd2) begin
            post_extent(dry, run_start - 28'd2, total, 1'b1, fcew_pkg::STAT_OK);
            return;
         end
         if (extents >= MAX_EXTENTS) begin
            post_extent(dry, run_start - 28'd2, total, 1'b1, fcew_pkg::STAT_LIMIT);
            return;
         end
         post_extent(dry, run_start - 28'd2, total, 1'b0, fcew_pkg::STAT_OK);
      end
   endfunction

   function automatic void apply_word(input req_word_type w);
      if (w.kind == fcew_pkg::KIND_LOAD)
         fat_mem[w.addr] = w.val;
      else
         walk_extents(w.head, 1'b0);
   endfunction

   function automatic void queue_load(input logic [15:0] a, input logic [7:0] v);
      req_word_type w;
      w.kind = fcew_pkg::KIND_LOAD;
      w.addr = a;
      w.val  = v;
      w.head = 28'($urandom);
      plan_mem[a] = v;
      plan_set[a] = 1'b1;
      pending_words.push_back(w);
      words_queued++;
   endfunction

   // Fill any table byte the walk would read before it has been written.
   function automatic void queue_walk(input logic [27:0] head);
      req_word_type w;
      dry_miss = 1'b1;
      while (dry_miss) begin
         dry_miss = 1'b0;
         walk_extents(head, 1'b1);
         if (dry_miss)
            queue_load(miss_addr, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF);
      end
      w.kind = fcew_pkg::KIND_WALK;
      w.addr = 16'($urandom);
      w.val  = 8'($urandom);
      w.head = head;
      pending_words.push_back(w);
      words_queued++;
   endfunction

   function automatic void set_entry(input logic [27:0] c, input logic [27:0] v);
      int unsigned off;
      logic [31:0] w;
      w = {4'($urandom), v};
      unique case (fat_sel)
         fcew_pkg::FAT_12: begin
            off = c + (c >> 1);
            if (off + 2 <= FAT_BYTES) begin
               if (c[0]) begin
                  queue_load(16'(off), {v[3:0], plan_mem[off][3:0]});
                  queue_load(16'(off + 1), v[11:4]);
               end else begin
                  queue_load(16'(off), v[7:0]);
                  queue_load(16'(off + 1), {plan_mem[off + 1][7:4], v[11:8]});
               end
            end
         end
         fcew_pkg::FAT_16: begin
            off = c * 2;
            if (off + 2 <= FAT_BYTES) begin
               queue_load(16'(off), w[7:0]);
               queue_load(16'(off + 1), w[15:8]);
            end
         end
         fcew_pkg::FAT_32: begin
            off = c * 4;
            if (off + 4 <= FAT_BYTES) begin
               queue_load(16'(off), w[7:0]);
               queue_load(16'(off + 1), w[15:8]);
               queue_load(16'(off + 2), w[23:16]);
               queue_load(16'(off + 3), w[31:24]);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [27:0] region_top();
      bit wide;
      wide = ($urandom_range(0, 4) == 0);
      unique case (fat_sel)
         fcew_pkg::FAT_12: return wide ? 28'h0FF7 : 28'd60;
         fcew_pkg::FAT_16: return wide ? 28'h7FFF : 28'd60;
         fcew_pkg::FAT_32: return wide ? 28'h3FFF : 28'd60;
         default:          return 28'd60;
      endcase
   endfunction

   function automatic logic [27:0] chain_tail();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 0)
         return 28'($urandom_range(0, 1));
      if (pick == 1)
         return 28'($urandom_range(2, region_top()));
      unique case (fat_sel)
         fcew_pkg::FAT_12: return 28'($urandom_range(12'hFF8, 12'hFFF));
         fcew_pkg::FAT_16: return (pick == 2) ? 28'($urandom_range(16'hFFF8, 16'hFFFF))
                                              : 28'($urandom_range(16'h8000, 16'hFFF7));
         default: return (pick == 2) ? 28'($urandom_range(28'hFFFFFF8, 28'hFFFFFFF))
                                     : 28'($urandom_range(28'h4000, 28'hFFFFFF7));
      endcase
   endfunction

   function automatic void build_chain(input logic [27:0] head, input int len);
      logic [27:0] cur;
      logic [27:0] nxt;
      cur = head;
      for (int i = 0; i < len; i++) begin
         if (i == len - 1)
            nxt = chain_tail();
         else if ($urandom_range(0, 1) == 1)
            nxt = cur + 28'd1;
         else
            nxt = 28'($urandom_range(2, region_top()));
         set_entry(cur, nxt);
         cur = nxt;
      end
   endfunction

   function automatic void random_phase(input int goal);
      int stop_at;
      int pick;
      logic [27:0] head;
      stop_at = words_queued + goal;
      while (words_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 55 && fat_sel != fcew_pkg::FAT_NONE) begin
            head = 28'($urandom_range(2, region_top()));
            build_chain(head, $urandom_range(1, 8));
            queue_walk(head);
         end else if (pick < 72) begin
            queue_walk(28'($urandom_range(2, region_top())));
         end else if (pick < 82) begin
            queue_walk(28'($urandom));
         end else if (pick < 87) begin
            queue_walk(28'($urandom_range(0, 1)));
         end else begin
            queue_load(16'($urandom), 8'($urandom));
         end
      end
   endfunction

   task automatic program_fat(input fcew_pkg::fat_kind_type ft);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(fcew_pkg::CSR_FAT_TYPE * 4);
      csr_pwdata  <= {30'd0, ft};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      fat_sel = ft;
   endtask

   task automatic drain_block();
      while (words_taken != words_queued || expected_extents.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_word(cur_word);
            words_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_words.size() > 0 && (free_flow || burst_left > 0)) begin
               cur_word = pending_words.pop_front();
               req_ch.kind          <= cur_word.kind;
               req_ch.byte_address  <= cur_word.addr;
               req_ch.byte_value    <= cur_word.val;
               req_ch.first_cluster <= cur_word.head;
               req_ch.valid         <= 1'b1;
               if (burst_left > 0) burst_left--;
            end else begin
               req_ch.valid <= 1'b0;
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                           : $urandom_range(0, 3);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
         rsp_open   = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_extents.size() == 0) begin
               report_error($sformatf("unexpected word start=%h count=%h last=%b status=%0d",
                            rsp_ch.extent_start, rsp_ch.run_end_count,
                            rsp_ch.last_extent, rsp_ch.status));
            end else begin
               want = expected_extents.pop_front();
               if (rsp_ch.extent_start !== want.start_cl)
                  report_error($sformatf("extent_start %h, want %h",
                               rsp_ch.extent_start, want.start_cl));
               if (rsp_ch.run_end_count !== want.end_count)
                  report_error($sformatf("run_end_count %h, want %h",
                               rsp_ch.run_end_count, want.end_count));
               if (rsp_ch.last_extent !== want.last_flag)
                  report_error($sformatf("last_extent %b, want %b",
                               rsp_ch.last_extent, want.last_flag));
               if (rsp_ch.status !== want.status)
                  report_error($sformatf("status %0d, want %0d",
                               rsp_ch.status, want.status));
            end
         end
         if (free_flow) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= rsp_open;
         end else begin
            rsp_open   = !rsp_open;
            stall_left = rsp_open ? $urandom_range(1, 10)
                       : (($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                      : $urandom_range(1, 3));
            rsp_ch.ready <= rsp_open;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.kind          = fcew_pkg::KIND_LOAD;
      req_ch.byte_address  = 16'd0;
      req_ch.byte_value    = 8'd0;
      req_ch.first_cluster = 28'd0;
      rsp_ch.ready         = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = 3'd0;
      csr_pwdata           = 32'd0;
      fat_sel              = fcew_pkg::FAT_12;
      free_flow            = 1'b0;
      words_queued         = 0;
      words_taken          = 0;
      error_count          = 0;
      idle_cycles          = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // FAT12 straight out of reset
      queue_walk(28'd0);
      queue_walk(28'd1);
      queue_walk(28'hFFFFFFF);
      set_entry(28'd2, 28'd3);
      set_entry(28'd3, 28'd4);
      set_entry(28'd4, 28'hFFF);
      queue_walk(28'd2);
      set_entry(28'd5, 28'd9);
      set_entry(28'd9, 28'd10);
      set_entry(28'd10, 28'hFF8);
      queue_walk(28'd5);
      random_phase(40);
      drain_block();

      program_fat(fcew_pkg::FAT_16);
      queue_walk(28'h8000);
      set_entry(28'd20, 28'h9000);
      queue_walk(28'd20);
      queue_walk(28'hFFF8);
      random_phase(40);
      drain_block();

      // loop between two clusters runs into the extent limit
      free_flow = 1'b1;
      program_fat(fcew_pkg::FAT_32);
      set_entry(28'd2, 28'd4);
      set_entry(28'd4, 28'd2);
      queue_walk(28'd2);
      queue_walk(28'hFFFFFF8);
      queue_walk(28'h4000);
      random_phase(40);
      drain_block();
      free_flow = 1'b0;

      program_fat(fcew_pkg::FAT_NONE);
      queue_walk(28'd7);
      queue_walk(28'd1);
      random_phase(15);
      drain_block();

      program_fat(fcew_pkg::FAT_12);
      random_phase(40);
      drain_block();

      program_fat(fcew_pkg::FAT_32);
      random_phase(40);
      drain_block();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
